[hdl/textured_wall_column_rasterizer_assert.svh]
// assertion macros for the wall column rasteriser
`ifndef TEXTURED_WALL_COLUMN_RASTERIZER_ASSERT_SVH
`define TEXTURED_WALL_COLUMN_RASTERIZER_ASSERT_SVH

// same-cycle implication
`define TWCR_ASSERT_IMP(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("twcr: same-cycle check failed");

// next-cycle implication
`define TWCR_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("twcr: next-cycle check failed");

`endif

[hdl/twcr_pkg.sv]
// shared types and constants for the wall column rasteriser
`timescale 1ns / 1ps

package twcr_pkg;

  localparam int DIST_W   = 16;
  localparam int NUM_W    = 22;
  localparam int CNT_W    = 5;
  localparam int HEIGHT_W = 15;
  localparam int VPOS_W   = 23;
  localparam int ADDR_W   = 11;
  localparam int IDX_W    = 10;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  localparam logic [1:0] REG_TEX_WIDTH  = 2'd0;
  localparam logic [1:0] REG_TEX_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MIN_DIST   = 2'd2;

  localparam logic [5:0] TEX_WIDTH_RST  = 6'd32;
  localparam logic [5:0] TEX_HEIGHT_RST = 6'd32;
  localparam logic [7:0] MIN_DIST_RST   = 8'd3;

  localparam logic [1:0] TEXEL_SET   = 2'd1;
  localparam logic [1:0] TEXEL_CLEAR = 2'd2;

  localparam logic [1:0] ACT_LEAVE = 2'd0;
  localparam logic [1:0] ACT_SET   = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[hdl/twcr_div.sv]
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module twcr_div import twcr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  numer,
  input  logic [DIST_W-1:0] denom,
  output logic [NUM_W-1:0]  quotient,
  output div_stat_t         stat
);

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  count;
  logic [DIST_W-1:0] rem;
  logic [DIST_W-1:0] den;
  logic [NUM_W-1:0]  quo;
  logic [DIST_W:0]   shifted;
  logic [DIST_W:0]   diff;
  logic              fits;

  assign shifted = {rem, quo[NUM_W-1]};
  assign fits    = shifted >= {1'b0, den};
  assign diff    = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= numer;
      den <= denom;
    end else if (busy) begin
      rem <= fits ? diff[DIST_W-1:0] : shifted[DIST_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

[hdl/textured_wall_column_rasterizer.sv]
// top level of the textured wall column rasteriser
//
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+----------
//   config   | psel penable pwrite paddr pwdata prdata   | in / out
//   request  | in_valid in_ready opcode .. tex_id        | in
//   pixel    | out_valid out_ready out_column .. last    | out
//
// a load request writes its byte to texture memory; a skipped column is accepted and dropped
// a drawn column passes the accept cycle, two divider runs of 22 steps each
// (height, then texture step) and three setup steps (ST_SETUP_H, ST_SETUP_V, ST_FILL),
// then one row per cycle (up to SCREEN_H rows) while out_ready is high
// the shared divider computes the height, then the texture step
// rows wait in place while the output register is held by out_ready
// synchronous reset clears control and config; texture memory is not cleared
`timescale 1ns / 1ps
`include "textured_wall_column_rasterizer_assert.svh"

module textured_wall_column_rasterizer import twcr_pkg::*; #(
  parameter int SCREEN_H     = 64,
  parameter int SCREEN_W     = 128,
  parameter int TEX_COUNT    = 8,
  parameter int TEX_MAX_SIDE = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [10:0] load_address,
  input  logic [7:0]  load_byte,
  input  logic [6:0]  column,
  input  logic [15:0] distance,
  input  logic [7:0]  tex_u,
  input  logic [2:0]  tex_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_column,
  output logic [5:0]  out_row,
  output logic [1:0]  pixel_action,
  output logic        last
);

  localparam int HEIGHT_NUM = SCREEN_H * 256;
  localparam logic signed [15:0] H_S = 16'(SCREEN_H);
  localparam logic signed [15:0] YMAX_S = 16'(SCREEN_H - 1);
  localparam logic [5:0] Y_MAX = 6'(SCREEN_H - 1);
  localparam logic [5:0] SIDE_MAX = 6'(TEX_MAX_SIDE);

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_DIV_H   = 7'b0000010,
    ST_SETUP_H = 7'b0000100,
    ST_DIV_V   = 7'b0001000,
    ST_SETUP_V = 7'b0010000,
    ST_FILL    = 7'b0100000,
    ST_ROWS    = 7'b1000000
  } state_t;

  state_t state;

  logic [5:0] cfg_width;
  logic [5:0] cfg_height;
  logic [7:0] cfg_min_dist;
  logic       cfg_we;

  logic [5:0] tw_c;
  logic [5:0] th_c;

  logic in_fire;
  logic skip;

  logic [6:0]          col_r;
  logic [2:0]          id_r;
  logic [7:0]          u_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [5:0]          row_r;
  logic [5:0]          ybot_r;
  logic [13:0]         negtop_r;
  logic [4:0]          texx_r;
  logic [NUM_W-1:0]    v_step;
  logic [VPOS_W-1:0]   v_pos;

  logic              div_start;
  logic [NUM_W-1:0]  div_numer;
  logic [DIST_W-1:0] div_denom;
  logic [NUM_W-1:0]  div_quo;
  div_stat_t         div_stat;

  logic signed [15:0] diff_s;
  logic signed [15:0] top_s;
  logic signed [15:0] negtop_s;
  logic signed [15:0] ybot_raw;
  logic [5:0]         ytop_c;
  logic [5:0]         ybot_c;
  logic [13:0]        ux_prod;
  logic [5:0]         tx_raw;
  logic [5:0]         tx_sat;
  logic [35:0]        vpos_prod;

  logic              out_free;
  logic              out_load;
  logic              row_is_last;
  logic              advance;
  logic [VPOS_W-1:0] vp_sel;
  logic [IDX_W-1:0]  idx_sel;
  logic [ADDR_W-1:0] rd_addr;

  logic [7:0] mem [2**ADDR_W];
  logic [7:0] rd_data;
  logic [1:0] rd_sel;
  logic [1:0] texel;
  logic [1:0] act;

  function automatic logic [5:0] clamp_side(input logic [5:0] v);
    logic [5:0] r;
    if (v == 6'd0) r = 6'd1;
    else if (v > SIDE_MAX) r = SIDE_MAX;
    else r = v;
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] tex_index(
    input logic [VPOS_W-1:0] vp,
    input logic [5:0]        tw,
    input logic [5:0]        th,
    input logic [4:0]        tx
  );
    logic [6:0]  ty_raw;
    logic [4:0]  ty;
    logic [10:0] sum;
    ty_raw = vp[VPOS_W-1:16];
    if (ty_raw >= {1'b0, th}) ty = 5'(th - 6'd1);
    else ty = ty_raw[4:0];
    sum = {6'b0, ty} * {5'b0, tw} + {6'b0, tx};
    return sum[IDX_W-1:0];
  endfunction

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width    <= TEX_WIDTH_RST;
      cfg_height   <= TEX_HEIGHT_RST;
      cfg_min_dist <= MIN_DIST_RST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_TEX_WIDTH:  cfg_width    <= pwdata[5:0];
        REG_TEX_HEIGHT: cfg_height   <= pwdata[5:0];
        REG_MIN_DIST:   cfg_min_dist <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TEX_WIDTH:  prdata = {26'b0, cfg_width};
      REG_TEX_HEIGHT: prdata = {26'b0, cfg_height};
      REG_MIN_DIST:   prdata = {24'b0, cfg_min_dist};
      default:        prdata = 32'b0;
    endcase
  end

  assign tw_c = clamp_side(cfg_width);
  assign th_c = clamp_side(cfg_height);

  // request side
  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  assign skip = (distance < {8'b0, cfg_min_dist}) || (distance == 16'd0) ||
                (tex_id == 3'd0) || ({1'b0, tex_id} >= 4'(TEX_COUNT)) ||
                ({1'b0, column} >= 8'(SCREEN_W)) ||
                ({1'b0, distance} > 17'(HEIGHT_NUM));

  // strip geometry
  assign diff_s   = H_S - $signed({1'b0, height_r});
  assign top_s    = (diff_s + $signed({15'b0, diff_s[15]})) >>> 1;
  assign negtop_s = -top_s;
  assign ybot_raw = top_s + $signed({1'b0, height_r}) - 16'sd1;
  assign ytop_c   = top_s[15] ? 6'd0 : top_s[5:0];
  assign ybot_c   = (ybot_raw > YMAX_S) ? Y_MAX : ybot_raw[5:0];
  assign ux_prod  = {6'b0, u_r} * {8'b0, tw_c};
  assign tx_raw   = ux_prod[13:8];
  assign tx_sat   = (tx_raw >= tw_c) ? (tw_c - 6'd1) : tx_raw;
  assign vpos_prod = {22'b0, negtop_r} * {14'b0, v_step};

  // divider control
  always_comb begin
    div_start = 1'b0;
    div_numer = NUM_W'(HEIGHT_NUM);
    div_denom = distance;
    if (state == ST_IDLE) begin
      div_start = in_fire && (opcode == OP_DRAW) && !skip;
    end else if (state == ST_SETUP_H) begin
      div_start = 1'b1;
      div_numer = {th_c, 16'b0};
      div_denom = {1'b0, height_r};
    end
  end

  twcr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (div_numer),
    .denom    (div_denom),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  // row stepping and texel fetch
  assign out_free    = !out_valid || out_ready;
  assign out_load    = (state == ST_ROWS) && out_free;
  assign row_is_last = (row_r == ybot_r);
  assign advance     = out_load && !row_is_last;
  assign vp_sel      = advance ? (v_pos + {1'b0, v_step}) : v_pos;
  assign idx_sel     = tex_index(vp_sel, tw_c, th_c, texx_r);
  assign rd_addr     = {id_r, idx_sel[IDX_W-1:2]};

  always_ff @(posedge clk) begin
    if (in_fire && (opcode == OP_LOAD)) begin
      mem[load_address] <= load_byte;
    end
    rd_data <= mem[rd_addr];
    rd_sel  <= idx_sel[1:0];
  end

  always_comb begin
    case (rd_sel)
      2'd0:    texel = rd_data[1:0];
      2'd1:    texel = rd_data[3:2];
      2'd2:    texel = rd_data[5:4];
      default: texel = rd_data[7:6];
    endcase
    case (texel)
      TEXEL_SET:   act = ACT_SET;
      TEXEL_CLEAR: act = ACT_CLEAR;
      default:     act = ACT_LEAVE;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (div_start) state <= ST_DIV_H;
        end
        ST_DIV_H: begin
          if (div_stat.done) state <= ST_SETUP_H;
        end
        ST_SETUP_H: begin
          state <= ST_DIV_V;
        end
        ST_DIV_V: begin
          if (div_stat.done) state <= ST_SETUP_V;
        end
        ST_SETUP_V: begin
          state <= ST_FILL;
        end
        ST_FILL: begin
          state <= ST_ROWS;
        end
        ST_ROWS: begin
          if (out_load && row_is_last) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      col_r <= column;
      id_r  <= tex_id;
      u_r   <= tex_u;
    end
    if ((state == ST_DIV_H) && div_stat.done) begin
      height_r <= div_quo[HEIGHT_W-1:0];
    end
    if (state == ST_SETUP_H) begin
      ybot_r   <= ybot_c;
      negtop_r <= top_s[15] ? negtop_s[13:0] : 14'd0;
      texx_r   <= tx_sat[4:0];
    end
    if ((state == ST_DIV_V) && div_stat.done) begin
      v_step <= div_quo;
    end
    if (state == ST_SETUP_V) begin
      v_pos <= vpos_prod[VPOS_W-1:0];
    end else if (advance) begin
      v_pos <= vp_sel;
    end
    if (state == ST_SETUP_H) begin
      row_r <= ytop_c;
    end else if (advance) begin
      row_r <= row_r + 6'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_column   <= col_r;
      out_row      <= row_r;
      pixel_action <= act;
      last         <= row_is_last;
    end
  end

  // checks
  `TWCR_ASSERT_IMP(a_ready_div_idle, clk, rst, in_ready, !div_stat.busy)
  `TWCR_ASSERT_NEXT(a_draw_starts_div, clk, rst, in_fire && (opcode == OP_DRAW) && !skip, div_stat.busy)
  `TWCR_ASSERT_IMP(a_row_in_range, clk, rst, state == ST_ROWS, row_r <= ybot_r)
  `TWCR_ASSERT_NEXT(a_last_frees_input, clk, rst, out_load && row_is_last, in_ready)

endmodule
